FILE: rtl/component_status_reporter_macros.svh
// Assertion macros for the component status reporter checker.
`ifndef COMPONENT_STATUS_REPORTER_MACROS_SVH
`define COMPONENT_STATUS_REPORTER_MACROS_SVH

// Concurrent check on clk, switched off while reset is asserted
`define CSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check on clk that also covers the reset sequence
`define CSR_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/csr_pkg.sv
// Types and constants shared by the component status reporter modules.
package csr_pkg;

	localparam int STATUS_W    = 8;
	localparam int TIME_W      = 32;
	localparam int RESEND_W    = 16;
	localparam int ID_W        = 11;
	localparam int LEN_W       = 3;
	localparam int CNT_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 56;

	localparam logic [STATUS_W-1:0] ERR_CODE_RST = 8'd2;
	localparam logic [RESEND_W-1:0] RESEND_RST   = 16'd500;
	localparam logic [ID_W-1:0]     MSG_ID_RST   = 11'd0;

	localparam logic [LEN_W-1:0] LEN_OK  = 3'd3;
	localparam logic [LEN_W-1:0] LEN_ERR = 3'd4;

	localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ERR_CODE = 2'd0,
		CFG_RESEND   = 2'd1,
		CFG_MSG_ID   = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		FUNC_REPORT = 1'b0,
		FUNC_READ   = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/component_status_reporter.sv
// Component status reporter: top level joining controller and datapath.
//
// Input stream s_axis: tuser selects the function (0 report, 1 read), tdata
// carries component, new status, error code and the millisecond time. Every
// input transaction gives exactly one output transaction on m_axis: tuser is
// the send flag, tdata holds the message fields and, for reads, the stored
// status. Registers are written through the cfg channel, which is always
// ready (index 0 error code, 1 resend interval, 2 message id).
// In order, the block captures the item on acceptance (ST_IDLE), registers
// the table read (ST_READ), compares and writes back (ST_EVAL), then builds
// the message from the per-bit counters and loads the result register
// (ST_EMIT) once the output register is free.
// A new item is accepted only once the previous result is loaded, so the
// block does not take an item while it is still busy with the last one.
// Reset clears the status and time tables through per-entry written marks at
// once, so no clearing pass is needed; the registers take their defaults.
// When the receiver stalls, the result stays in the output register and the
// block finishes its next item, then waits until that result is taken.
module component_status_reporter
	import csr_pkg::*;
	#(
		parameter int NUM_COMPONENTS = 256
	)
	(
		input  logic                   clk,
		input  logic                   arst_n,
		input  logic                   s_axis_tvalid,
		output logic                   s_axis_tready,
		// component, new_status, error_code, now_ms
		input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
		// func
		input  logic                   s_axis_tuser,
		output logic                   m_axis_tvalid,
		input  logic                   m_axis_tready,
		// out_message_id, system_status, sent_component, sent_status,
		// sent_error_code, message_length, read_status, zero pad
		output logic [OUT_TDATA_W-1:0] m_axis_tdata,
		// send
		output logic                   m_axis_tuser,
		input  logic                   cfg_valid,
		output logic                   cfg_ready,
		input  logic [CFG_IDX_W-1:0]   cfg_index,
		input  logic [CFG_DATA_W-1:0]  cfg_data
	);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	csr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	csr_dp #(.NUM_COMPONENTS(NUM_COMPONENTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: rtl/csr_ram.sv
// Generic single-port RAM with registered read data.
module csr_ram
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 256
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] addr,
		input  logic [WIDTH-1:0]         wdata,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, register the read word every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/csr_ctrl.sv
// Controller state machine of the component status reporter.
module csr_ctrl
	import csr_pkg::*;
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     s_axis_tvalid,
		output logic     s_axis_tready,
		input  dp_stat_t stat,
		output dp_cmd_t  cmd
	);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/csr_dp.sv
// Datapath of the component status reporter: tables, bit counters, result register.
module csr_dp
	import csr_pkg::*;
	#(
		parameter int NUM_COMPONENTS = 256
	)
	(
		input  logic                   clk,
		input  logic                   arst_n,
		input  dp_cmd_t                cmd,
		output dp_stat_t               stat,
		input  logic                   cfg_valid,
		input  logic [CFG_IDX_W-1:0]   cfg_index,
		input  logic [CFG_DATA_W-1:0]  cfg_data,
		input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
		input  logic                   s_axis_tuser,
		output logic                   m_axis_tvalid,
		input  logic                   m_axis_tready,
		output logic [OUT_TDATA_W-1:0] m_axis_tdata,
		output logic                   m_axis_tuser
	);

	localparam int AW = $clog2(NUM_COMPONENTS);

	logic [STATUS_W-1:0] err_code_q;
	logic [RESEND_W-1:0] resend_q;
	logic [ID_W-1:0]     msg_id_q;

	logic                func_q;
	logic [7:0]          comp_q;
	logic [STATUS_W-1:0] new_st_q;
	logic [7:0]          ec_q;
	logic [TIME_W-1:0]   now_q;

	logic [NUM_COMPONENTS-1:0] valid_q;
	logic [CNT_W-1:0]          cnt_q [STATUS_W];

	logic                tx_q;
	logic                is_err_q;
	logic [STATUS_W-1:0] rd_st_q;

	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;
	logic                   m_tvalid_q;

	logic [AW-1:0]       addr;
	logic [STATUS_W-1:0] st_rdata;
	logic [TIME_W-1:0]   t_rdata;
	logic [STATUS_W-1:0] old_st;
	logic [TIME_W-1:0]   old_t;
	logic [TIME_W-1:0]   age;
	logic                in_range;
	logic                is_report;
	logic                do_upd;
	logic                tx;
	logic [TIME_W-1:0]   t_wdata;
	logic [STATUS_W-1:0] bits_set;
	logic [STATUS_W-1:0] overall;

	assign addr      = comp_q[AW-1:0];
	assign in_range  = {1'b0, comp_q} < 9'(NUM_COMPONENTS);
	assign is_report = (func_t'(func_q) == FUNC_REPORT);
	assign do_upd    = cmd.eval && is_report && in_range;

	// Entries never written read as zero
	assign old_st = valid_q[addr] ? st_rdata : '0;
	assign old_t  = valid_q[addr] ? t_rdata : '0;

	// Decide on a message: status change or resend interval exceeded
	assign age     = now_q - old_t;
	assign tx      = (old_st != new_st_q) || (age > {16'd0, resend_q});
	assign t_wdata = tx ? now_q : old_t;

	csr_ram #(.WIDTH(STATUS_W), .DEPTH(NUM_COMPONENTS)) u_status_ram (
		.clk   (clk),
		.we    (do_upd),
		.addr  (addr),
		.wdata (new_st_q),
		.rdata (st_rdata)
	);

	csr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_COMPONENTS)) u_time_ram (
		.clk   (clk),
		.we    (do_upd),
		.addr  (addr),
		.wdata (t_wdata),
		.rdata (t_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_code_q <= ERR_CODE_RST;
			resend_q   <= RESEND_RST;
			msg_id_q   <= MSG_ID_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ERR_CODE: err_code_q <= cfg_data[STATUS_W-1:0];
				CFG_RESEND:   resend_q   <= cfg_data[RESEND_W-1:0];
				CFG_MSG_ID:   msg_id_q   <= cfg_data[ID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= s_axis_tuser;
			comp_q   <= s_axis_tdata[7:0];
			new_st_q <= s_axis_tdata[15:8];
			ec_q     <= s_axis_tdata[23:16];
			now_q    <= s_axis_tdata[55:24];
		end
	end

	// Written marks for the tables, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_upd) begin
			valid_q[addr] <= 1'b1;
		end
	end

	// Track how many components have each status bit set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < STATUS_W; b++) begin
				cnt_q[b] <= '0;
			end
		end else if (do_upd) begin
			for (int b = 0; b < STATUS_W; b++) begin
				if (old_st[b] && !new_st_q[b] && cnt_q[b] != '0) begin
					cnt_q[b] <= cnt_q[b] - 1'b1;
				end else if (!old_st[b] && new_st_q[b] && cnt_q[b] != CNT_MAX) begin
					cnt_q[b] <= cnt_q[b] + 1'b1;
				end
			end
		end
	end

	// Hold the evaluation result until the message is built
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			tx_q     <= do_upd && tx;
			is_err_q <= (new_st_q == err_code_q);
			rd_st_q  <= (!is_report && in_range) ? old_st : '0;
		end
	end

	// Overall status from the bit counters
	always_comb begin
		for (int b = 0; b < STATUS_W; b++) begin
			bits_set[b] = (cnt_q[b] != '0);
		end
		overall = ((bits_set & err_code_q) != '0) ? err_code_q : bits_set;
	end

	// Result register; field order from bit 0: id, overall, component, status,
	// error code, length, read status
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tuser_q <= tx_q;
			m_tdata_q <= {2'b00,
				rd_st_q,
				tx_q ? (is_err_q ? LEN_ERR : LEN_OK) : LEN_W'(0),
				(tx_q && is_err_q) ? ec_q : 8'd0,
				tx_q ? new_st_q : 8'd0,
				tx_q ? comp_q : 8'd0,
				tx_q ? overall : 8'd0,
				tx_q ? msg_id_q : ID_W'(0)};
		end
	end

	// Output valid: set on load, drop when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign stat.out_free = !m_tvalid_q || m_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

FILE: rtl/csr_checker.sv
// Port-level checks for the component status reporter, bound to the top level.
`include "component_status_reporter_macros.svh"

module csr_checker
	import csr_pkg::*;
	(
		input logic                   clk,
		input logic                   arst_n,
		input logic                   s_axis_tvalid,
		input logic                   s_axis_tready,
		input logic                   m_axis_tvalid,
		input logic                   m_axis_tready,
		input logic [OUT_TDATA_W-1:0] m_axis_tdata,
		input logic                   m_axis_tuser
	);

	// No result is offered right after reset is released
	`CSR_ASSERT_RST(a_no_result_at_reset, $rose(arst_n) |-> !m_axis_tvalid, "result valid at reset release")

	// One item at a time: input closes after a transaction
	`CSR_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input open after accept")

	// A stalled result holds its payload
	`CSR_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// A message has length 3 or 4
	`CSR_ASSERT(a_sent_length, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[45:43] == LEN_OK || m_axis_tdata[45:43] == LEN_ERR, "bad message length")

	// No message means empty message fields
	`CSR_ASSERT(a_quiet_fields, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[45:0] == '0, "message fields set without send")

endmodule

bind component_status_reporter csr_checker u_csr_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the component status reporter stream block.
module testbench
	import csr_pkg::*;
	();

	localparam int NUM_COMP         = 256;
	localparam int CYCLE_LIMIT      = 500000;
	localparam int SETTLE_CYCLES    = 16;
	localparam int SINK_HOLD_CYCLES = 300;

	// Status message fields as carried on m_axis, send flag from tuser on top
	typedef struct packed {
		logic              send;
		logic [7:0]        rd;
		logic [LEN_W-1:0]  len;
		logic [7:0]        err;
		logic [7:0]        sts;
		logic [7:0]        comp;
		logic [7:0]        overall;
		logic [ID_W-1:0]   msg_id;
	} status_msg_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// component, new_status, error_code, now_ms
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// func
	func_t                  s_axis_tuser = FUNC_REPORT;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// out_message_id, system_status, sent_component, sent_status,
	// sent_error_code, message_length, read_status, zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// send
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	cfg_idx_t               cfg_index = CFG_ERR_CODE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Mirror of the block state and registers
	logic [7:0]          comp_status  [NUM_COMP] = '{default: '0};
	logic [31:0]         comp_last_ms [NUM_COMP] = '{default: '0};
	logic [CNT_W-1:0]    bit_counts   [8]        = '{default: '0};
	logic [7:0]          cfg_err_code = ERR_CODE_RST;
	logic [RESEND_W-1:0] cfg_resend   = RESEND_RST;
	logic [ID_W-1:0]     cfg_msg_id   = MSG_ID_RST;

	status_msg_t pending_msgs [$];
	int          fail_count = 0;
	logic [31:0] sim_ms = '0;
	logic        src_idle_on = 1'b1;
	logic        sink_idle_on = 1'b1;
	logic        sink_hold_req = 1'b0;

	component_status_reporter #(.NUM_COMPONENTS(NUM_COMP)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Store the report, update per-bit counts and build the resulting message
	function automatic status_msg_t predict_message(input func_t f, input logic [7:0] comp,
		input logic [7:0] st, input logic [7:0] ec, input logic [31:0] now);
		status_msg_t m;
		logic [7:0]  old_st;
		logic [7:0]  acc;
		logic [31:0] elapsed;
		m = '0;
		if (int'(comp) >= NUM_COMP)
			return m;
		if (f == FUNC_READ) begin
			m.rd = comp_status[comp];
			return m;
		end
		old_st  = comp_status[comp];
		elapsed = now - comp_last_ms[comp];
		for (int b = 0; b < 8; b++) begin
			if (old_st[b] && !st[b] && bit_counts[b] != '0)
				bit_counts[b]--;
			else if (!old_st[b] && st[b] && bit_counts[b] != CNT_MAX)
				bit_counts[b]++;
		end
		comp_status[comp] = st;
		// changed status, or the resend interval ran out (wrapping time)
		if (old_st != st || elapsed > 32'(cfg_resend)) begin
			acc = '0;
			for (int b = 0; b < 8; b++)
				acc[b] = (bit_counts[b] != '0);
			if ((acc & cfg_err_code) != '0)
				acc = cfg_err_code;
			m.send    = 1'b1;
			m.msg_id  = cfg_msg_id;
			m.overall = acc;
			m.comp    = comp;
			m.sts     = st;
			if (st == cfg_err_code) begin
				m.err = ec;
				m.len = LEN_ERR;
			end else begin
				m.len = LEN_OK;
			end
			comp_last_ms[comp] = now;
		end
		return m;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Offer one item, optionally after an idle burst, and hold until accepted
	task automatic send_item(input func_t f, input logic [7:0] comp, input logic [7:0] st,
		input logic [7:0] ec, input logic [31:0] now);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= f;
		s_axis_tdata  <= {now, ec, st, comp};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_msgs.push_back(predict_message(f, comp, st, ec, now));
	endtask

	// Build a report or read that mostly revisits a small set of components
	task automatic send_random_item(input int pool);
		func_t      f;
		logic [7:0] comp;
		logic [7:0] st;
		int         pick;
		f = ($urandom_range(0, 4) == 0) ? FUNC_READ : FUNC_REPORT;
		if ($urandom_range(0, 7) != 0)
			comp = 8'($urandom_range(0, pool - 1));
		else
			comp = 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 4)
			st = comp_status[comp];
		else if (pick < 6)
			st = cfg_err_code;
		else if (pick == 6)
			st = '0;
		else
			st = 8'($urandom);
		// advance time around the resend interval, sometimes jump anywhere
		if ($urandom_range(0, 24) == 0)
			sim_ms = $urandom;
		else
			sim_ms = sim_ms + 32'($urandom_range(0, 2 * int'(cfg_resend) + 2));
		send_item(f, comp, st, 8'($urandom), sim_ms);
	endtask

	// Stop offering and wait until every message is back and the block is quiet
	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ERR_CODE: cfg_err_code = val[7:0];
			CFG_RESEND:   cfg_resend   = val;
			CFG_MSG_ID:   cfg_msg_id   = val[ID_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] err, input logic [15:0] resend,
		input logic [ID_W-1:0] id);
		write_reg(CFG_ERR_CODE, 16'(err));
		write_reg(CFG_RESEND, resend);
		write_reg(CFG_MSG_ID, 16'(id));
	endtask

	// Boundaries of the resend window, time wrap, error status and reads
	task automatic test_directed();
		send_item(FUNC_READ,   8'd0,   8'h00, 8'h00, 32'd0);
		send_item(FUNC_READ,   8'd255, 8'h00, 8'h00, 32'd0);
		send_item(FUNC_REPORT, 8'd0,   8'h00, 8'h00, 32'd0);
		send_item(FUNC_REPORT, 8'd1,   8'h00, 8'h00, 32'd500);
		send_item(FUNC_REPORT, 8'd1,   8'h00, 8'h00, 32'd501);
		send_item(FUNC_REPORT, 8'd255, 8'hFF, 8'hAB, 32'hFFFF_FFFF);
		send_item(FUNC_REPORT, 8'd255, 8'hFF, 8'hAB, 32'h0000_01F3);
		send_item(FUNC_REPORT, 8'd255, 8'hFF, 8'h54, 32'h0000_01F4);
		send_item(FUNC_REPORT, 8'd3,   ERR_CODE_RST, 8'h5A, 32'h0000_01F4);
		send_item(FUNC_REPORT, 8'd3,   ERR_CODE_RST, 8'h77, 32'h0000_01F4);
		send_item(FUNC_REPORT, 8'd255, 8'h00, 8'hFF, 32'h0000_01F5);
		send_item(FUNC_REPORT, 8'd4,   8'h01, 8'h00, 32'h8000_0000);
		send_item(FUNC_REPORT, 8'd3,   8'h00, 8'h00, 32'h8000_0000);
		send_item(FUNC_READ,   8'd3,   8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(FUNC_READ,   8'd4,   8'h00, 8'h00, 32'd0);
		send_item(FUNC_REPORT, 8'd5,   8'hFD, 8'hFF, 32'h7FFF_FFFF);
		send_item(FUNC_READ,   8'd5,   8'h00, 8'h00, 32'd0);
		wait_for_idle();
	endtask

	// Walk the register extremes with a batch of traffic under each
	task automatic test_config_extremes();
		logic [7:0]      errs   [5] = '{8'd1, 8'd255, 8'h80, 8'h41, 8'd2};
		logic [15:0]     resends[5] = '{16'd0, 16'd65535, 16'd1, 16'd250, 16'd500};
		logic [ID_W-1:0] ids    [5] = '{11'd2047, 11'd0, 11'h555, 11'h2AA, 11'd1};
		for (int s = 0; s < 5; s++) begin
			apply_settings(errs[s], resends[s], ids[s]);
			for (int i = 0; i < 60; i++)
				send_random_item(8);
			wait_for_idle();
		end
	endtask

	// Hold the output off for a long stretch so the block backs up into its input
	task automatic test_output_holdoff();
		sink_hold_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_random_item(16);
		wait_for_idle();
	endtask

	// Long random traffic under random register settings
	task automatic test_random_traffic();
		for (int s = 0; s < 3; s++) begin
			apply_settings(8'($urandom_range(1, 255)), 16'($urandom_range(0, 1000)),
				ID_W'($urandom_range(0, 2047)));
			for (int i = 0; i < 220; i++)
				send_random_item((s == 2) ? 256 : 12);
			wait_for_idle();
		end
	endtask

	// Full-rate traffic on both sides
	task automatic test_full_rate();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		apply_settings(8'h06, 16'd100, 11'h3C3);
		for (int i = 0; i < 150; i++)
			send_random_item(10);
		wait_for_idle();
	endtask

	// Receiver: random stall bursts plus the requested long hold-off
	initial begin : result_sink
		int stall;
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 18);
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each output transaction with the oldest pending message
	always @(posedge clk) begin : message_check
		status_msg_t got;
		status_msg_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[53:0]};
			if (pending_msgs.size() == 0) begin
				$error("output transaction with nothing pending: %h", got);
				fail_count++;
			end else begin
				want = pending_msgs.pop_front();
				check_field("send", 32'(want.send), 32'(got.send));
				check_field("out_message_id", 32'(want.msg_id), 32'(got.msg_id));
				check_field("system_status", 32'(want.overall), 32'(got.overall));
				check_field("sent_component", 32'(want.comp), 32'(got.comp));
				check_field("sent_status", 32'(want.sts), 32'(got.sts));
				check_field("sent_error_code", 32'(want.err), 32'(got.err));
				check_field("message_length", 32'(want.len), 32'(got.len));
				check_field("read_status", 32'(want.rd), 32'(got.rd));
			end
		end
	end

	// Abort a hung run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : main_seq
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_output_holdoff();
		test_random_traffic();
		test_full_rate();
		if (pending_msgs.size() != 0) begin
			$error("%0d messages never arrived", pending_msgs.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
